FILE: design/csp_pkg.sv
// Package for the clock select and prescaler register block.
// Holds the shared status codes, register offsets, clock constants and transaction types.
// No dependencies.
package csp_pkg;

    // Status codes returned with every result transaction.
    typedef enum logic [3:0] {
        ST_OK               = 4'd0,
        ST_RESERVED_READ    = 4'd1,
        ST_BAD_SOURCE       = 4'd2,
        ST_XOSC_UNSUPPORTED = 4'd3,
        ST_CCP_PROTECTED    = 4'd4,
        ST_BAD_PSADIV       = 4'd5,
        ST_UNLOCK_REFUSED   = 4'd6,
        ST_BAD_RTC_SOURCE   = 4'd7,
        ST_NOT_WRITABLE     = 4'd8,
        ST_PLL_RANGE        = 4'd9
    } status_t;

    // Access kinds.
    localparam logic ACCESS_READ  = 1'b0;
    localparam logic ACCESS_WRITE = 1'b1;

    // Register offsets.
    localparam logic [3:0] ADDR_CTRL    = 4'd0;
    localparam logic [3:0] ADDR_PSCTRL  = 4'd1;
    localparam logic [3:0] ADDR_LOCK    = 4'd2;
    localparam logic [3:0] ADDR_RTCCTRL = 4'd3;

    // System clock sources.
    localparam logic [2:0] SRC_RC2M  = 3'd0;
    localparam logic [2:0] SRC_RC32M = 3'd1;
    localparam logic [2:0] SRC_RC32K = 3'd2;
    localparam logic [2:0] SRC_XOSC  = 3'd3;
    localparam logic [2:0] SRC_PLL   = 3'd4;

    // Real-time-clock sources that are accepted.
    localparam logic [2:0] RTC_ULP    = 3'd0;
    localparam logic [2:0] RTC_TOSC   = 3'd1;
    localparam logic [2:0] RTC_RCOSC  = 3'd2;
    localparam logic [2:0] RTC_TOSC32 = 3'd5;

    // Frequencies in Hz.
    localparam logic [31:0] FREQ_RC2M  = 32'd2000000;
    localparam logic [31:0] FREQ_RC32M = 32'd32000000;
    localparam logic [31:0] FREQ_RC32K = 32'd32768;
    localparam logic [31:0] PLL_MAX    = 32'd200000000;
    localparam logic [31:0] PLL_MIN    = 32'd10000000;

    localparam logic [7:0] PSCTRL_MASK = 8'h7F;
    localparam logic [4:0] PSADIV_MAX  = 5'd9;

    // One bus access.
    typedef struct packed {
        logic       kind;
        logic [3:0] address;
        logic [7:0] write_data;
        logic       ccp_open;
    } access_t;

    // One result.
    typedef struct packed {
        logic [7:0]  read_data;
        status_t     status;
        logic [31:0] system_frequency;
        logic [5:0]  prescale_a;
        logic [2:0]  prescale_b;
        logic [1:0]  prescale_c;
        logic        clock_changed;
    } result_t;

    function automatic logic [31:0] sys_freq(input logic [2:0] src, input logic [31:0] pll);
        logic [31:0] f;
        case (src)
            SRC_RC2M:  f = FREQ_RC2M;
            SRC_RC32M: f = FREQ_RC32M;
            SRC_RC32K: f = FREQ_RC32K;
            SRC_PLL:   f = pll;
            default:   f = 32'd0;
        endcase
        return f;
    endfunction

    function automatic logic [5:0] ratio_a(input logic [6:0] psctrl);
        logic [4:0] d;
        logic [2:0] amt;
        d   = psctrl[6:2];
        amt = d[3:1] + 3'd1;
        if (d == 5'd0) begin
            return 6'd1;
        end
        return 6'd1 << amt;
    endfunction

    function automatic logic [2:0] ratio_b(input logic [6:0] psctrl);
        logic [2:0] r;
        case (psctrl[1:0])
            2'd2:    r = 3'd4;
            2'd3:    r = 3'd2;
            default: r = 3'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] ratio_c(input logic [6:0] psctrl);
        return psctrl[0] ? 2'd2 : 2'd1;
    endfunction

endpackage

FILE: design/csp_in_stage.sv
// Input register stage of the clock select and prescaler register block.
// Depends on csp_pkg for the access transaction type.
module csp_in_stage
    import csp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  access_t s_access,
    output logic    hold_valid,
    output access_t hold_access,
    input  logic    advance
);

    logic    valid_reg, valid_next;
    access_t access_reg;

    // The stage can take a transaction when empty or when its content moves on.
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            access_reg <= s_access;
        end
    end

    assign hold_valid  = valid_reg;
    assign hold_access = access_reg;

endmodule

FILE: design/csp_regfile.sv
// Register file and access decode of the clock select and prescaler register block.
// Depends on csp_pkg for codes, constants, transaction types and ratio functions.
module csp_regfile
    import csp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        commit,
    input  access_t     access,
    input  logic [31:0] pll_frequency,
    output result_t     result
);

    logic [2:0] source_reg, source_next;
    logic [6:0] psctrl_reg, psctrl_next;
    logic       lock_reg, lock_next;
    logic       rtc_en_reg, rtc_en_next;
    logic [2:0] rtc_src_reg, rtc_src_next;

    logic [7:0] rd;
    status_t    status;
    logic       changed;
    logic [2:0] new_src;
    logic [4:0] new_psadiv;
    logic [2:0] new_rtc;
    logic       pll_bad;

    always_comb begin
        source_next  = source_reg;
        psctrl_next  = psctrl_reg;
        lock_next    = lock_reg;
        rtc_en_next  = rtc_en_reg;
        rtc_src_next = rtc_src_reg;
        rd           = 8'd0;
        status       = ST_OK;
        changed      = 1'b0;
        new_src      = access.write_data[2:0];
        new_psadiv   = access.write_data[6:2];
        new_rtc      = access.write_data[3:1];

        if (access.kind == ACCESS_READ) begin
            case (access.address)
                ADDR_CTRL:    rd = {5'd0, source_reg};
                ADDR_PSCTRL:  rd = {1'b0, psctrl_reg};
                ADDR_LOCK:    rd = {7'd0, lock_reg};
                ADDR_RTCCTRL: rd = {4'd0, rtc_src_reg, rtc_en_reg};
                default:      status = ST_RESERVED_READ;
            endcase
        end else if (access.address == ADDR_CTRL && !lock_reg) begin
            if (new_src > SRC_PLL) begin
                status = ST_BAD_SOURCE;
            end else if (!access.ccp_open) begin
                status = ST_CCP_PROTECTED;
            end else if (new_src == SRC_XOSC) begin
                status = ST_XOSC_UNSUPPORTED;
            end else begin
                source_next = new_src;
                changed     = 1'b1;
            end
        end else if (access.address == ADDR_PSCTRL && !lock_reg) begin
            if (new_psadiv > PSADIV_MAX || (new_psadiv != 5'd0 && !new_psadiv[0])) begin
                status = ST_BAD_PSADIV;
            end else begin
                psctrl_next = access.write_data[6:0] & PSCTRL_MASK[6:0];
                changed     = 1'b1;
            end
        end else if (access.address == ADDR_LOCK) begin
            if (!lock_reg && access.write_data != 8'd0) begin
                if (access.ccp_open) begin
                    lock_next = 1'b1;
                end else begin
                    status = ST_CCP_PROTECTED;
                end
            end else if (lock_reg && access.write_data == 8'd0) begin
                status = ST_UNLOCK_REFUSED;
            end
        end else if (access.address == ADDR_RTCCTRL) begin
            rtc_en_next = access.write_data[0];
            if (new_rtc == RTC_ULP || new_rtc == RTC_TOSC || new_rtc == RTC_RCOSC
                || new_rtc == RTC_TOSC32) begin
                rtc_src_next = new_rtc;
            end else begin
                status = ST_BAD_RTC_SOURCE;
            end
        end else begin
            status = ST_NOT_WRITABLE;
        end

        // An applied clock change with the PLL selected flags an out-of-range PLL.
        pll_bad = (pll_frequency > PLL_MAX) || (pll_frequency < PLL_MIN);
        if (changed && source_next == SRC_PLL && pll_bad) begin
            status = ST_PLL_RANGE;
        end

        result.read_data        = rd;
        result.status           = status;
        result.system_frequency = sys_freq(source_next, pll_frequency);
        result.prescale_a       = ratio_a(psctrl_next);
        result.prescale_b       = ratio_b(psctrl_next);
        result.prescale_c       = ratio_c(psctrl_next);
        result.clock_changed    = changed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_reg  <= SRC_RC2M;
            psctrl_reg  <= 7'd0;
            lock_reg    <= 1'b0;
            rtc_en_reg  <= 1'b0;
            rtc_src_reg <= RTC_ULP;
        end else if (commit) begin
            source_reg  <= source_next;
            psctrl_reg  <= psctrl_next;
            lock_reg    <= lock_next;
            rtc_en_reg  <= rtc_en_next;
            rtc_src_reg <= rtc_src_next;
        end
    end

endmodule

FILE: design/csp_out_stage.sv
// Result register stage of the clock select and prescaler register block.
// Depends on csp_pkg for the result transaction type.
module csp_out_stage
    import csp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t load_result,
    output logic    load_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg, valid_next;
    result_t result_reg;

    assign load_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

FILE: design/clock_select_prescaler_regs_core.sv
// Top level of the clock select and prescaler register block.
// Depends on csp_pkg, csp_in_stage, csp_regfile and csp_out_stage.
//
// Clock control register window. Each input transaction is one bus read or write to four
// registers: CTRL (source select, offset 0), PSCTRL (prescaler, offset 1), LOCK (offset 2) and
// RTCCTRL (offset 3); offsets 4 to 15 are reserved. Writes are checked, and a rejected write
// leaves its register unchanged, though a rejected RTCCTRL write still updates the enable bit,
// and reports a status code. Every transaction yields exactly one result transaction carrying
// read data, status, the system frequency, the three prescaler ratios and a change flag, all
// reflecting the state after the access. A transaction is registered on entry, decoded and
// applied to the register file by short logic once the result stage can take it, and the
// result is registered on the way out; one transaction is taken every cycle while the result
// side keeps up. The result register frees itself in the same cycle it is taken, so a stalled
// result side holds at most one transaction in each stage. The PLL frequency is written
// through the configuration channel, which is always ready; it should be written only while
// no transaction is in flight.
module clock_select_prescaler_regs_core
    import csp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [3:0]  s_address,
    input  logic [7:0]  s_write_data,
    input  logic        s_ccp_open,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [3:0]  m_status,
    output logic [31:0] m_system_frequency,
    output logic [5:0]  m_prescale_a,
    output logic [2:0]  m_prescale_b,
    output logic [1:0]  m_prescale_c,
    output logic        m_clock_changed
);

    logic [31:0] pll_frequency_reg;
    access_t     s_access;
    logic        hold_valid;
    access_t     hold_access;
    logic        advance;
    logic        load_ready;
    result_t     decoded;
    result_t     m_result;

    // The PLL frequency register accepts a write in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pll_frequency_reg <= 32'd0;
        end else if (cfg_valid && cfg_ready) begin
            pll_frequency_reg <= cfg_data;
        end
    end

    assign s_access = '{kind: s_kind, address: s_address, write_data: s_write_data,
                        ccp_open: s_ccp_open};

    // A held transaction is applied to the registers exactly when it moves into the result stage.
    assign advance = hold_valid && load_ready;

    csp_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_access    (s_access),
        .hold_valid  (hold_valid),
        .hold_access (hold_access),
        .advance     (advance)
    );

    csp_regfile u_regfile (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .commit        (advance),
        .access        (hold_access),
        .pll_frequency (pll_frequency_reg),
        .result        (decoded)
    );

    csp_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance),
        .load_result (decoded),
        .load_ready  (load_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

    assign m_read_data        = m_result.read_data;
    assign m_status           = m_result.status;
    assign m_system_frequency = m_result.system_frequency;
    assign m_prescale_a       = m_result.prescale_a;
    assign m_prescale_b       = m_result.prescale_b;
    assign m_prescale_c       = m_result.prescale_c;
    assign m_clock_changed    = m_result.clock_changed;

endmodule

FILE: dv/clock_select_prescaler_regs_core_test.sv
// Self-checking testbench for clock_select_prescaler_regs_core.
// Depends on csp_pkg and the block itself; a behavioural predictor in this file
// supplies the expected result for every access but the typed opening rows.
module clock_select_prescaler_regs_core_test;
    import csp_pkg::*;

    // Offsets beyond the four real registers; everything between them is reserved as well.
    localparam logic [3:0] ADDR_RESERVED_LO = 4'd4;
    localparam logic [3:0] ADDR_RESERVED_HI = 4'd15;

    // Opening table rows either carry a typed status (checked directly) or defer to the predictor.
    localparam logic TYPED   = 1'b1;
    localparam logic PREDICT = 1'b0;

    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 92;
    localparam int SETTLE_CYCLES  = 8;

    // Every typed row is issued while the source, prescaler and lock still hold their reset
    // state, so the expected result is the reset view with only the status changed.
    localparam result_t AT_RESET = '{8'h00, ST_OK, FREQ_RC2M, 6'd1, 3'd1, 2'd1, 1'b0};

    // Source and divider values that the block accepts, used to bias random writes.
    localparam logic [2:0] GOOD_SOURCE [4] = '{SRC_RC2M, SRC_RC32M, SRC_RC32K, SRC_PLL};
    localparam logic [4:0] GOOD_PSADIV [6] = '{5'd0, 5'd1, 5'd3, 5'd5, 5'd7, 5'd9};

    typedef struct packed {
        access_t acc;
        logic    typed;
        status_t want_status;
    } dir_row_t;

    // The directed opening: register reads at reset, reserved offsets, every rejection path
    // that is reachable from reset, then accepted source and prescaler writes (the PLL is
    // selected while its frequency is still 0, which must report out of range), RTC control
    // and read-back. The lock itself is only set at the start of the last phase, since it
    // freezes the clock registers for the remainder of the run.
    localparam dir_row_t OPENING [26] = '{
        '{'{ACCESS_READ,  ADDR_CTRL,        8'h00, 1'b0}, TYPED,   ST_OK},
        '{'{ACCESS_READ,  ADDR_PSCTRL,      8'h00, 1'b0}, TYPED,   ST_OK},
        '{'{ACCESS_READ,  ADDR_LOCK,        8'h00, 1'b0}, TYPED,   ST_OK},
        '{'{ACCESS_READ,  ADDR_RTCCTRL,     8'h00, 1'b0}, TYPED,   ST_OK},
        '{'{ACCESS_READ,  ADDR_RESERVED_HI, 8'h00, 1'b0}, TYPED,   ST_RESERVED_READ},
        '{'{ACCESS_READ,  ADDR_RESERVED_LO, 8'hFF, 1'b1}, TYPED,   ST_RESERVED_READ},
        '{'{ACCESS_WRITE, ADDR_RESERVED_HI, 8'hFF, 1'b1}, TYPED,   ST_NOT_WRITABLE},
        '{'{ACCESS_WRITE, ADDR_CTRL,        8'hFD, 1'b1}, TYPED,   ST_BAD_SOURCE},
        '{'{ACCESS_WRITE, ADDR_CTRL,        8'h07, 1'b0}, TYPED,   ST_BAD_SOURCE},
        '{'{ACCESS_WRITE, ADDR_CTRL,        8'h01, 1'b0}, TYPED,   ST_CCP_PROTECTED},
        '{'{ACCESS_WRITE, ADDR_CTRL,        8'h03, 1'b1}, TYPED,   ST_XOSC_UNSUPPORTED},
        '{'{ACCESS_WRITE, ADDR_LOCK,        8'h00, 1'b1}, TYPED,   ST_OK},
        '{'{ACCESS_WRITE, ADDR_LOCK,        8'h80, 1'b0}, TYPED,   ST_CCP_PROTECTED},
        '{'{ACCESS_WRITE, ADDR_RTCCTRL,     8'hFF, 1'b0}, TYPED,   ST_BAD_RTC_SOURCE},
        '{'{ACCESS_WRITE, ADDR_PSCTRL,      8'hFF, 1'b1}, TYPED,   ST_BAD_PSADIV},
        '{'{ACCESS_WRITE, ADDR_PSCTRL,      8'h08, 1'b0}, TYPED,   ST_BAD_PSADIV},
        '{'{ACCESS_WRITE, ADDR_CTRL,        8'h01, 1'b1}, PREDICT, ST_OK},
        '{'{ACCESS_WRITE, ADDR_CTRL,        8'hFA, 1'b1}, PREDICT, ST_OK},
        '{'{ACCESS_WRITE, ADDR_CTRL,        8'h04, 1'b1}, PREDICT, ST_OK},
        '{'{ACCESS_WRITE, ADDR_PSCTRL,      8'h27, 1'b0}, PREDICT, ST_OK},
        '{'{ACCESS_WRITE, ADDR_PSCTRL,      8'h86, 1'b1}, PREDICT, ST_OK},
        '{'{ACCESS_WRITE, ADDR_RTCCTRL,     8'h0B, 1'b1}, PREDICT, ST_OK},
        '{'{ACCESS_READ,  ADDR_RTCCTRL,     8'h00, 1'b1}, PREDICT, ST_OK},
        '{'{ACCESS_READ,  ADDR_PSCTRL,      8'h00, 1'b0}, PREDICT, ST_OK},
        '{'{ACCESS_WRITE, ADDR_CTRL,        8'h00, 1'b1}, PREDICT, ST_OK},
        '{'{ACCESS_READ,  ADDR_CTRL,        8'hFF, 1'b1}, PREDICT, ST_OK}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [3:0]  s_address;
    logic [7:0]  s_write_data;
    logic        s_ccp_open;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_read_data;
    logic [3:0]  m_status;
    logic [31:0] m_system_frequency;
    logic [5:0]  m_prescale_a;
    logic [2:0]  m_prescale_b;
    logic [1:0]  m_prescale_c;
    logic        m_clock_changed;

    // Shadow copy of the register file and the PLL setting, as the block should hold them.
    logic [31:0] pll_hz    = '0;
    logic [2:0]  clk_src   = SRC_RC2M;
    logic [6:0]  ps_ctrl   = '0;
    logic        locked    = 1'b0;
    logic        rtc_en    = 1'b0;
    logic [2:0]  rtc_src   = RTC_ULP;

    result_t pending_results [$];
    int      mismatches = 0;

    // When calm is set, neither side idles, so the block runs at full rate for a phase.
    bit calm       = 1'b0;
    int burst_left = 0;
    int stall_left = 0;

    clock_select_prescaler_regs_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_address          (s_address),
        .s_write_data       (s_write_data),
        .s_ccp_open         (s_ccp_open),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_read_data        (m_read_data),
        .m_status           (m_status),
        .m_system_frequency (m_system_frequency),
        .m_prescale_a       (m_prescale_a),
        .m_prescale_b       (m_prescale_b),
        .m_prescale_c       (m_prescale_c),
        .m_clock_changed    (m_clock_changed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Applies one access to the shadow registers and returns the result the block should give.
    // The frequency and ratios always reflect the state after the access has been applied.
    function automatic result_t predict_access(input access_t acc);
        result_t     r;
        logic [2:0]  src;
        logic [6:0]  ps;
        logic [2:0]  rsrc;

        r    = '0;
        src  = acc.write_data[2:0];
        ps   = acc.write_data[6:0];
        rsrc = acc.write_data[3:1];
        r.status = ST_OK;

        if (acc.kind == ACCESS_READ) begin
            case (acc.address)
                ADDR_CTRL:    r.read_data = {5'd0, clk_src};
                ADDR_PSCTRL:  r.read_data = {1'b0, ps_ctrl};
                ADDR_LOCK:    r.read_data = {7'd0, locked};
                ADDR_RTCCTRL: r.read_data = {4'd0, rtc_src, rtc_en};
                default:      r.status = ST_RESERVED_READ;
            endcase
        end else if (acc.address == ADDR_CTRL && !locked) begin
            // The source range is checked ahead of change protection.
            if (src > SRC_PLL) begin
                r.status = ST_BAD_SOURCE;
            end else if (!acc.ccp_open) begin
                r.status = ST_CCP_PROTECTED;
            end else if (src == SRC_XOSC) begin
                r.status = ST_XOSC_UNSUPPORTED;
            end else begin
                clk_src = src;
                r.clock_changed = 1'b1;
            end
        end else if (acc.address == ADDR_PSCTRL && !locked) begin
            // Only odd dividers up to 9, or zero, are legal.
            if (ps[6:2] > PSADIV_MAX || (ps[6:2] != 5'd0 && !ps[2])) begin
                r.status = ST_BAD_PSADIV;
            end else begin
                ps_ctrl = ps;
                r.clock_changed = 1'b1;
            end
        end else if (acc.address == ADDR_LOCK) begin
            if (!locked && acc.write_data != 8'd0) begin
                if (acc.ccp_open) begin
                    locked = 1'b1;
                end else begin
                    r.status = ST_CCP_PROTECTED;
                end
            end else if (locked && acc.write_data == 8'd0) begin
                r.status = ST_UNLOCK_REFUSED;
            end
        end else if (acc.address == ADDR_RTCCTRL) begin
            rtc_en = acc.write_data[0];
            if (rsrc <= RTC_RCOSC || rsrc == RTC_TOSC32) begin
                rtc_src = rsrc;
            end else begin
                r.status = ST_BAD_RTC_SOURCE;
            end
        end else begin
            r.status = ST_NOT_WRITABLE;
        end

        // A new configuration is still applied with the PLL out of range, but flagged.
        if (r.clock_changed && clk_src == SRC_PLL && (pll_hz > PLL_MAX || pll_hz < PLL_MIN)) begin
            r.status = ST_PLL_RANGE;
        end

        case (clk_src)
            SRC_RC2M:  r.system_frequency = FREQ_RC2M;
            SRC_RC32M: r.system_frequency = FREQ_RC32M;
            SRC_RC32K: r.system_frequency = FREQ_RC32K;
            SRC_PLL:   r.system_frequency = pll_hz;
            default:   r.system_frequency = 32'd0;
        endcase

        r.prescale_a = (ps_ctrl[6:2] == 5'd0) ? 6'd1 : (6'd1 << (ps_ctrl[6:3] + 4'd1));
        case (ps_ctrl[1:0])
            2'd2:    r.prescale_b = 3'd4;
            2'd3:    r.prescale_b = 3'd2;
            default: r.prescale_b = 3'd1;
        endcase
        r.prescale_c = ps_ctrl[0] ? 2'd2 : 2'd1;
        return r;
    endfunction

    // Random accesses are shaped so that most writes carry a legal source or divider and so
    // reach the paths that change the clock; the rest are noise and rejected values. Outside
    // the final phase a write that would set the lock has its protection flag cleared instead.
    function automatic access_t random_access(input bit lock_allowed);
        access_t acc;

        acc.kind       = ($urandom_range(0, 2) != 0) ? ACCESS_WRITE : ACCESS_READ;
        acc.write_data = 8'($urandom);
        acc.ccp_open   = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 99) < 15) begin
            acc.address = 4'($urandom_range(ADDR_RESERVED_LO, ADDR_RESERVED_HI));
        end else begin
            acc.address = 4'($urandom_range(ADDR_CTRL, ADDR_RTCCTRL));
        end

        case (acc.address)
            ADDR_CTRL: begin
                if ($urandom_range(0, 3) != 0) begin
                    acc.write_data[2:0] = GOOD_SOURCE[$urandom_range(0, 3)];
                end
            end
            ADDR_PSCTRL: begin
                if ($urandom_range(0, 9) < 7) begin
                    acc.write_data[6:2] = GOOD_PSADIV[$urandom_range(0, 5)];
                end
            end
            ADDR_LOCK: begin
                if ($urandom_range(0, 2) == 0) begin
                    acc.write_data = 8'd0;
                end
                if (!lock_allowed && acc.kind == ACCESS_WRITE && acc.write_data != 8'd0) begin
                    acc.ccp_open = 1'b0;
                end
            end
            default: ;
        endcase
        return acc;
    endfunction

    // Presents one access, holding it until accepted, and queues its expected result. Entered
    // and left on a falling edge. Between bursts the sender drops valid for a random gap.
    task automatic send_access(input access_t acc, input logic typed, input status_t st);
        result_t want;
        int      gap;

        if (!calm) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end

        s_valid      <= 1'b1;
        s_kind       <= acc.kind;
        s_address    <= acc.address;
        s_write_data <= acc.write_data;
        s_ccp_open   <= acc.ccp_open;
        do @(posedge aclk); while (!s_ready);

        want = predict_access(acc);
        if (typed) begin
            want        = AT_RESET;
            want.status = st;
        end
        pending_results.push_back(want);
        @(negedge aclk);
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // Receiver: ready is normally high, with stalls of random length starting now and then.
    always @(negedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every result transaction is matched against the oldest outstanding expectation.
    always @(posedge aclk) begin
        result_t want;

        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no expectation, expected none, actual status %0d data %0d",
                         $time, m_status, m_read_data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("read_data",        32'(want.read_data),     32'(m_read_data));
                check_field("status",           32'(want.status),        32'(m_status));
                check_field("system_frequency", want.system_frequency,   m_system_frequency);
                check_field("prescale_a",       32'(want.prescale_a),    32'(m_prescale_a));
                check_field("prescale_b",       32'(want.prescale_b),    32'(m_prescale_b));
                check_field("prescale_c",       32'(want.prescale_c),    32'(m_prescale_c));
                check_field("clock_changed",    32'(want.clock_changed), 32'(m_clock_changed));
            end
        end
    end

    initial begin
        logic [31:0] pll_next;

        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_kind       = ACCESS_READ;
        s_address    = ADDR_CTRL;
        s_write_data = '0;
        s_ccp_open   = 1'b0;
        m_ready      = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The opening table runs with the PLL frequency still at its reset value of 0.
        foreach (OPENING[i]) begin
            send_access(OPENING[i].acc, OPENING[i].typed, OPENING[i].want_status);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            // The PLL frequency may only change with nothing in flight, so drain the block and
            // allow for its pipeline registers before touching the configuration channel.
            s_valid <= 1'b0;
            while (pending_results.size() != 0) @(negedge aclk);
            repeat (4) @(negedge aclk);

            // Both range limits, the values just outside them, the full-scale extremes and
            // random settings in and out of range.
            case (ph)
                0:       pll_next = 32'hFFFF_FFFF;
                1:       pll_next = PLL_MIN;
                2:       pll_next = PLL_MAX;
                3:       pll_next = PLL_MIN - 32'd1;
                4:       pll_next = PLL_MAX + 32'd1;
                5:       pll_next = $urandom_range(PLL_MIN, PLL_MAX);
                6:       pll_next = 32'd0;
                default: pll_next = $urandom;
            endcase
            cfg_valid <= 1'b1;
            cfg_data  <= pll_next;
            do @(posedge aclk); while (!cfg_ready);
            pll_hz = pll_next;
            @(negedge aclk);
            cfg_valid <= 1'b0;

            calm = (ph == 2);

            // The final phase sets the lock first, so that the frozen registers, the refused
            // unlock and repeated lock writes are all seen under random traffic.
            if (ph == PHASES - 1) begin
                send_access('{ACCESS_WRITE, ADDR_LOCK, 8'h01, 1'b1}, PREDICT, ST_OK);
            end
            repeat (ITEMS_PER_PHASE) begin
                send_access(random_access(ph == PHASES - 1), PREDICT, ST_OK);
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far longer than the slowest legal run, with every gap and stall at its longest.
    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
design/csp_pkg.sv
design/csp_in_stage.sv
design/csp_regfile.sv
design/csp_out_stage.sv
design/clock_select_prescaler_regs_core.sv
dv/clock_select_prescaler_regs_core_test.sv
